>>> rtl/binomial_blur_gradient_edge_classifier_core_macros.svh
// assertion helpers shared by the blur core
`ifndef BINOMIAL_BLUR_GRADIENT_EDGE_CLASSIFIER_CORE_MACROS_SVH
`define BINOMIAL_BLUR_GRADIENT_EDGE_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BBGEC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BBGEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bbgec_pkg.sv
`default_nettype none
package bbgec_pkg;

  // field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SIZE_W     = 13;
  localparam int THR_W      = 9;
  localparam int PIX_W      = 8;
  localparam int MAG_W      = 9;
  localparam int LABEL_W    = 8;

  // datapath widths
  localparam int KW_W   = 7;
  localparam int WT_W   = 9;
  localparam int ACC_W  = 16;
  localparam int SQ_W   = 17;
  localparam int RING_W = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LEVEL_ONE    = 3'd2,
    REG_LEVEL_TWO    = 3'd3,
    REG_LEVEL_THREE  = 3'd4,
    REG_LEVEL_FOUR   = 3'd5
  } cfg_reg_t;

  // request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // labels
  localparam logic [LABEL_W-1:0] LABEL_NONE  = 8'd0;
  localparam logic [LABEL_W-1:0] LABEL_ONE   = 8'd64;
  localparam logic [LABEL_W-1:0] LABEL_TWO   = 8'd128;
  localparam logic [LABEL_W-1:0] LABEL_THREE = 8'd192;
  localparam logic [LABEL_W-1:0] LABEL_FOUR  = 8'd255;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET      = 13'd4096;
  localparam logic [THR_W-1:0]  THR_ONE_RESET   = 9'd20;
  localparam logic [THR_W-1:0]  THR_TWO_RESET   = 9'd50;
  localparam logic [THR_W-1:0]  THR_THREE_RESET = 9'd100;
  localparam logic [THR_W-1:0]  THR_FOUR_RESET  = 9'd200;

  localparam logic [SIZE_W:0] SIZE_MIN = 14'd3;

  // kernel geometry
  localparam logic [3:0] KERN_TAPS = 4'd9;
  localparam logic [3:0] KERN_HALF = 4'd4;

  // largest magnitude the datapath can produce
  localparam logic [MAG_W-1:0] MAG_LIMIT = 9'd360;

  // binomial kernel weights
  function automatic logic [KW_W-1:0] kern_weight(input logic [3:0] k);
    logic [KW_W-1:0] w;
    case (k)
      4'd0, 4'd8: w = 7'd1;
      4'd1, 4'd7: w = 7'd8;
      4'd2, 4'd6: w = 7'd28;
      4'd3, 4'd5: w = 7'd56;
      4'd4:       w = 7'd70;
      default:    w = 7'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bbgec_if.sv
`default_nettype none
// pixel / drain request channel
interface bbgec_in_if import bbgec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, op, pixel, input ready);
  modport sink   (input valid, op, pixel, output ready);
endinterface

// classified result channel
interface bbgec_out_if import bbgec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] edge_label;
  logic [MAG_W-1:0]   magnitude;
  logic               frame_end;
  modport source (output valid, edge_label, magnitude, frame_end, input ready);
  modport sink   (input valid, edge_label, magnitude, frame_end, output ready);
endinterface

// register write channel
interface bbgec_cfg_if import bbgec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/binomial_blur_gradient_edge_classifier_core.sv
// Blur, gradient and edge classifier for 8-bit raster frames. Pixels go into a
// 16-row ring memory; each output is then computed by a sequencer that reads
// the ring one tap per cycle through a shared accumulator, a shared 8-step
// divider for the border-normalised blur and a 9-step square root. Outputs
// lag the input by 5*W+4 pixels; drain requests flush them at the end of a
// frame. A request that produces no output leaves the sequencer idle, a
// border output goes straight to the result register, and an interior
// output works through four blurred points, each up to 9 rows of tap reads
// plus a divide and accumulate, paced by the single read port of the ring
// memory. Register writes are accepted only while the sequencer is idle and
// no request is offered; a size write restarts the frame.
`default_nettype none
module binomial_blur_gradient_edge_classifier_core import bbgec_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bbgec_cfg_if.sink       cfg_if,
  bbgec_in_if.sink        in_if,
  bbgec_out_if.source     out_if
);

  `include "binomial_blur_gradient_edge_classifier_core_macros.svh"

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(5 * MAX_WIDTH + 5);
  localparam int PSW = ((WW > RW) ? WW : RW) + 2;
  localparam int AW  = RING_W + CIW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VROW, ST_HTAP, ST_HDIV, ST_VACC, ST_VDIV,
    ST_SQX, ST_SQY, ST_ROOT, ST_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [SIZE_W-1:0] width_r, height_r;
  logic [THR_W-1:0]  thr_r [4];

  // frame position
  logic [CIW-1:0] in_col_r, out_col_r;
  logic [RW-1:0]  in_row_r, out_row_r;
  logic [PW-1:0]  pend_r;

  // sequencer
  logic [1:0]       g_r;
  logic [3:0]       kv_r, kh_r;
  logic             tv_r;
  logic [KW_W-1:0]  tk_r;
  logic [ACC_W-1:0] hacc_r, vacc_r;
  logic [WT_W-1:0]  hwt_r, vwt_r;
  logic [ACC_W-1:0] div_num_r;
  logic [WT_W-1:0]  div_den_r;
  logic [7:0]       div_q_r;
  logic [2:0]       div_i_r;
  logic [7:0]       vb_r [4];
  logic [SQ_W-1:0]  sq_r;
  logic [MAG_W-1:0] root_r, mag_r;
  logic [3:0]       ri_r;

  // result register
  logic               out_valid_r, out_end_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [MAG_W-1:0]   out_mag_r;

  // ring memory
  logic [PIX_W-1:0] ring_mem [2**AW];
  logic [PIX_W-1:0] mem_q;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr, mem_waddr;

  // effective frame size
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [PW-1:0] lag;

  always_comb begin
    if ({1'b0, width_r} < SIZE_MIN) eff_w = WW'(SIZE_MIN);
    else if ({1'b0, width_r} > (SIZE_W+1)'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if ({1'b0, height_r} < SIZE_MIN) eff_h = RW'(SIZE_MIN);
    else if ({1'b0, height_r} > (SIZE_W+1)'(MAX_HEIGHT)) eff_h = RW'(MAX_HEIGHT);
    else eff_h = RW'(height_r);
    lag = (PW'(eff_w) << 2) + PW'(eff_w) + PW'(KERN_HALF);
  end

  // request decode
  logic in_fire, cfg_fire, all_in, is_pixel, pix_store, emit, border;
  logic [WW-1:0] in_col_inc, out_col_inc;
  logic [RW-1:0] in_row_inc, out_row_inc;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = (state_r == ST_IDLE) && !in_if.valid;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign all_in       = (in_row_r >= eff_h);
  assign is_pixel     = (in_if.op == OP_PIXEL);
  assign pix_store    = in_fire && is_pixel && !all_in;
  assign emit         = in_fire && ((is_pixel && !all_in && pend_r == lag) ||
                                    (!is_pixel && all_in));
  assign in_col_inc   = WW'(in_col_r) + WW'(1);
  assign in_row_inc   = in_row_r + RW'(1);
  assign out_col_inc  = WW'(out_col_r) + WW'(1);
  assign out_row_inc  = out_row_r + RW'(1);
  assign border       = (out_row_r == '0) || (out_col_r == '0) ||
                        (out_row_inc >= eff_h) || (out_col_inc >= eff_w);

  // blurred point under work and current tap
  logic signed [PSW-1:0] pr, pc, rr, cc;
  logic row_ok, col_ok;

  always_comb begin
    pr = $signed(PSW'(out_row_r));
    pc = $signed(PSW'(out_col_r));
    case (g_r)
      2'd0:    pc = pc + $signed(PSW'(1));
      2'd1:    pc = pc - $signed(PSW'(1));
      2'd2:    pr = pr + $signed(PSW'(1));
      default: pr = pr - $signed(PSW'(1));
    endcase
    rr = pr + $signed(PSW'(kv_r)) - $signed(PSW'(KERN_HALF));
    cc = pc + $signed(PSW'(kh_r)) - $signed(PSW'(KERN_HALF));
    row_ok = (rr >= 0) && (rr < $signed(PSW'(eff_h)));
    col_ok = (kh_r < KERN_TAPS) && (cc >= 0) && (cc < $signed(PSW'(eff_w)));
  end

  assign mem_re    = (state_r == ST_HTAP) && col_ok;
  assign mem_raddr = {rr[RING_W-1:0], cc[CIW-1:0]};
  assign mem_waddr = {in_row_r[RING_W-1:0], in_col_r};

  // ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (pix_store) ring_mem[mem_waddr] <= in_if.pixel;
    if (mem_re) mem_q <= ring_mem[mem_raddr];
  end

  // tap accumulate
  logic [ACC_W-1:0] hacc_sum;
  assign hacc_sum = hacc_r + (tv_r ? ACC_W'(mem_q) * ACC_W'(tk_r) : '0);

  // restoring divide step, quotient known to fit 8 bits
  logic [ACC_W:0]   div_sh;
  logic             div_ge;
  logic [ACC_W-1:0] div_num_step;
  logic [7:0]       div_q_step;

  always_comb begin
    div_sh       = (ACC_W+1)'(div_den_r) << div_i_r;
    div_ge       = ({1'b0, div_num_r} >= div_sh);
    div_num_step = div_ge ? ACC_W'({1'b0, div_num_r} - div_sh) : div_num_r;
    div_q_step   = div_q_r | (div_ge ? (8'd1 << div_i_r) : 8'd0);
  end

  // gradient and square root
  logic signed [8:0]  gx, gy;
  logic signed [17:0] gxx, gyy;
  logic [MAG_W-1:0]   root_try;
  logic [17:0]        root_sq;

  always_comb begin
    gx       = $signed({1'b0, vb_r[0]}) - $signed({1'b0, vb_r[1]});
    gy       = $signed({1'b0, vb_r[2]}) - $signed({1'b0, vb_r[3]});
    gxx      = gx * gx;
    gyy      = gy * gy;
    root_try = root_r | (MAG_W'(1) << ri_r);
    root_sq  = {9'b0, root_try} * {9'b0, root_try};
  end

  // classification of the finished magnitude
  logic [LABEL_W-1:0] label_nxt;
  logic               out_load, frame_end_nxt;

  always_comb begin
    if (mag_r >= thr_r[3]) label_nxt = LABEL_FOUR;
    else if (mag_r >= thr_r[2]) label_nxt = LABEL_THREE;
    else if (mag_r >= thr_r[1]) label_nxt = LABEL_TWO;
    else if (mag_r >= thr_r[0]) label_nxt = LABEL_ONE;
    else label_nxt = LABEL_NONE;
  end

  assign out_load      = (state_r == ST_OUT) && (!out_valid_r || out_if.ready);
  assign frame_end_nxt = (out_col_inc >= eff_w) && (out_row_inc >= eff_h);

  // sequencer, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= SIZE_RESET;
      height_r    <= SIZE_RESET;
      thr_r[0]    <= THR_ONE_RESET;
      thr_r[1]    <= THR_TWO_RESET;
      thr_r[2]    <= THR_THREE_RESET;
      thr_r[3]    <= THR_FOUR_RESET;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && !out_load) out_valid_r <= 1'b0;

      // register writes
      if (cfg_fire) begin
        case (cfg_reg_t'(cfg_if.index))
          REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
            if (cfg_reg_t'(cfg_if.index) == REG_FRAME_WIDTH) width_r <= cfg_if.data;
            else height_r <= cfg_if.data;
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
            pend_r    <= '0;
          end
          REG_LEVEL_ONE:   thr_r[0] <= cfg_if.data[THR_W-1:0];
          REG_LEVEL_TWO:   thr_r[1] <= cfg_if.data[THR_W-1:0];
          REG_LEVEL_THREE: thr_r[2] <= cfg_if.data[THR_W-1:0];
          REG_LEVEL_FOUR:  thr_r[3] <= cfg_if.data[THR_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          // input position and pending count
          if (pix_store) begin
            if (in_col_inc >= eff_w) begin
              in_col_r <= '0;
              in_row_r <= in_row_inc;
            end else begin
              in_col_r <= in_col_inc[CIW-1:0];
            end
            if (!emit) pend_r <= pend_r + PW'(1);
          end else if (emit) begin
            pend_r <= pend_r - PW'(1);
          end
          if (emit) begin
            if (border) begin
              mag_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              g_r     <= 2'd0;
              kv_r    <= '0;
              vacc_r  <= '0;
              vwt_r   <= '0;
              state_r <= ST_VROW;
            end
          end
        end

        ST_VROW: begin
          if (kv_r == KERN_TAPS) begin
            div_num_r <= vacc_r;
            div_den_r <= vwt_r;
            div_q_r   <= '0;
            div_i_r   <= 3'd7;
            state_r   <= ST_VDIV;
          end else if (row_ok) begin
            kh_r    <= '0;
            hacc_r  <= '0;
            hwt_r   <= '0;
            tv_r    <= 1'b0;
            state_r <= ST_HTAP;
          end else begin
            kv_r <= kv_r + 4'd1;
          end
        end

        // one read issued, previous read accumulated
        ST_HTAP: begin
          hacc_r <= hacc_sum;
          tv_r   <= col_ok;
          tk_r   <= kern_weight(kh_r);
          if (col_ok) hwt_r <= hwt_r + WT_W'(kern_weight(kh_r));
          if (kh_r == KERN_TAPS) begin
            div_num_r <= hacc_sum;
            div_den_r <= hwt_r;
            div_q_r   <= '0;
            div_i_r   <= 3'd7;
            state_r   <= ST_HDIV;
          end else begin
            kh_r <= kh_r + 4'd1;
          end
        end

        ST_HDIV: begin
          div_num_r <= div_num_step;
          div_q_r   <= div_q_step;
          div_i_r   <= div_i_r - 3'd1;
          if (div_i_r == 3'd0) state_r <= ST_VACC;
        end

        ST_VACC: begin
          vacc_r  <= vacc_r + ACC_W'(div_q_r) * ACC_W'(kern_weight(kv_r));
          vwt_r   <= vwt_r + WT_W'(kern_weight(kv_r));
          kv_r    <= kv_r + 4'd1;
          state_r <= ST_VROW;
        end

        ST_VDIV: begin
          div_num_r <= div_num_step;
          div_q_r   <= div_q_step;
          div_i_r   <= div_i_r - 3'd1;
          if (div_i_r == 3'd0) begin
            vb_r[g_r] <= div_q_step;
            if (g_r == 2'd3) begin
              state_r <= ST_SQX;
            end else begin
              g_r     <= g_r + 2'd1;
              kv_r    <= '0;
              vacc_r  <= '0;
              vwt_r   <= '0;
              state_r <= ST_VROW;
            end
          end
        end

        ST_SQX: begin
          sq_r    <= gxx[SQ_W-1:0];
          state_r <= ST_SQY;
        end

        ST_SQY: begin
          sq_r    <= sq_r + gyy[SQ_W-1:0];
          root_r  <= '0;
          ri_r    <= 4'(MAG_W - 1);
          state_r <= ST_ROOT;
        end

        // one root bit a cycle
        ST_ROOT: begin
          if (root_sq <= {1'b0, sq_r}) root_r <= root_try;
          if (ri_r == 4'd0) begin
            mag_r   <= (root_sq <= {1'b0, sq_r}) ? root_try : root_r;
            state_r <= ST_OUT;
          end else begin
            ri_r <= ri_r - 4'd1;
          end
        end

        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_label_r <= label_nxt;
            out_mag_r   <= mag_r;
            out_end_r   <= frame_end_nxt;
            if (frame_end_nxt) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              pend_r    <= '0;
            end else if (out_col_inc >= eff_w) begin
              out_col_r <= '0;
              out_row_r <= out_row_inc;
            end else begin
              out_col_r <= out_col_inc[CIW-1:0];
            end
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.edge_label = out_label_r;
  assign out_if.magnitude  = out_mag_r;
  assign out_if.frame_end  = out_end_r;

  // checks
  `BBGEC_ASSERT_SAME(a_mag_range, out_if.valid, out_if.magnitude <= MAG_LIMIT, "magnitude out of range")
  `BBGEC_ASSERT_SAME(a_pend_bound, 1'b1, pend_r <= lag, "pending count beyond lag")
  `BBGEC_ASSERT_NEXT(a_frame_restart, out_load && frame_end_nxt, (in_row_r == '0) && (pend_r == '0), "frame not restarted")

endmodule
`default_nettype wire
